// ----- src/idud_pkg.sv -----
// ----------------------------------------------------------------------------
// idud_pkg
// Shared types and constants for the integer determinant block.
// ----------------------------------------------------------------------------
package idud_pkg;

    localparam int DET_WIDTH           = 43;
    localparam int CFG_WIDTH           = 3;
    localparam int MAX_SIZE_DEFAULT    = 5;
    localparam int ELEM_WIDTH_DEFAULT  = 8;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_CHECK,
        ST_READ,
        ST_MUL,
        ST_ACC,
        ST_OUT
    } idud_state_t;

endpackage

// ----- src/integer_determinant_up_to_5x5.sv -----
// ----------------------------------------------------------------------------
// integer_determinant_up_to_5x5
// Exact determinant of a square signed matrix loaded one element per transfer.
// ----------------------------------------------------------------------------
// Elements are taken row-major, one per cycle, into a small synchronous
// memory. After the last element of an s x s matrix the block walks every
// s-digit column tuple; a tuple that is a permutation reads its s elements
// from memory one after another (one shared multiplier) and adds or
// subtracts the product. The result then sits in an output register until
// transferred, and the next matrix can load meanwhile; input is stalled
// while the walk runs and, at its end, until the output register is free.
// Writing matrix_size discards a partly loaded matrix.
module integer_determinant_up_to_5x5
#(
    parameter int MAX_SIZE      = idud_pkg::MAX_SIZE_DEFAULT,
    parameter int ELEMENT_WIDTH = idud_pkg::ELEM_WIDTH_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              matrix_size_we,
    input  logic [idud_pkg::CFG_WIDTH-1:0]    matrix_size,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [ELEMENT_WIDTH-1:0]   element_value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [idud_pkg::DET_WIDTH-1:0] determinant
);
    import idud_pkg::*;

    localparam int DEPTH = MAX_SIZE * MAX_SIZE;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int IW    = $clog2(MAX_SIZE);
    localparam int SW    = $clog2(MAX_SIZE + 1);

    logic signed [ELEMENT_WIDTH-1:0] mem [DEPTH];
    logic signed [ELEMENT_WIDTH-1:0] rdata_reg;

    idud_state_t state_reg, state_next;
    logic [CFG_WIDTH-1:0]  size_cfg_reg;
    logic [CW-1:0]         count_reg, count_next;
    logic [IW-1:0]         digit_reg [MAX_SIZE];
    logic [IW-1:0]         digit_next [MAX_SIZE];
    logic [IW-1:0]         row_reg, row_next;
    logic signed [DET_WIDTH-1:0] prod_reg, prod_next;
    logic signed [DET_WIDTH-1:0] acc_reg, acc_next;
    logic                  odd_reg, odd_next;
    logic signed [DET_WIDTH-1:0] det_reg, det_next;
    logic                  out_valid_reg, out_valid_next;

    logic [SW-1:0]  size_eff;
    logic [CW-1:0]  total;
    logic           in_xfer;
    logic           out_xfer;
    logic [AW-1:0]  raddr;
    logic           distinct;
    logic           parity;
    logic [IW-1:0]  digit_inc [MAX_SIZE];
    logic           wrap;
    logic           carry;
    logic signed [DET_WIDTH+ELEMENT_WIDTH-1:0] mul_full;

    // effective size: zero counts as one, above the maximum saturates
    always_comb
    begin
        if (size_cfg_reg == '0)
            size_eff = SW'(1);
        else if (32'(size_cfg_reg) > MAX_SIZE)
            size_eff = SW'(MAX_SIZE);
        else
            size_eff = SW'(size_cfg_reg);
        total = CW'(size_eff) * CW'(size_eff);
    end

    assign in_stall  = (state_reg != ST_LOAD);
    assign in_xfer   = in_valid && !in_stall;
    assign out_xfer  = out_valid_reg && !out_stall;
    assign out_valid = out_valid_reg;
    assign determinant = det_reg;

    // permutation test and sign over the active digits
    always_comb
    begin
        distinct = 1'b1;
        parity   = 1'b0;
        for (int i = 0; i < MAX_SIZE; i++)
        begin
            for (int j = i + 1; j < MAX_SIZE; j++)
            begin
                if (j < 32'(size_eff))
                begin
                    if (digit_reg[i] == digit_reg[j])
                        distinct = 1'b0;
                    if (digit_reg[i] > digit_reg[j])
                        parity = ~parity;
                end
            end
        end
    end

    // base-s increment, last active digit fastest
    always_comb
    begin
        carry = 1'b1;
        for (int i = MAX_SIZE - 1; i >= 0; i--)
        begin
            digit_inc[i] = digit_reg[i];
            if (i < 32'(size_eff) && carry)
            begin
                if (32'(digit_reg[i]) == 32'(size_eff) - 1)
                    digit_inc[i] = '0;
                else
                begin
                    digit_inc[i] = digit_reg[i] + IW'(1);
                    carry = 1'b0;
                end
            end
        end
        wrap = carry;
    end

    assign raddr    = AW'(AW'(row_reg) * AW'(size_eff) + AW'(digit_reg[row_reg]));
    assign mul_full = prod_reg * rdata_reg;

    always_ff @(posedge clk)
    begin
        if (in_xfer)
            mem[count_reg[AW-1:0]] <= element_value;
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            size_cfg_reg  <= CFG_WIDTH'(5);
            count_reg     <= '0;
            row_reg       <= '0;
            odd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_SIZE; i++)
                digit_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            odd_reg       <= odd_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < MAX_SIZE; i++)
                digit_reg[i] <= digit_next[i];
            if (matrix_size_we)
            begin
                size_cfg_reg <= matrix_size;
                count_reg    <= '0;
            end
            else
                count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        det_reg  <= det_next;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        row_next   = row_reg;
        odd_next   = odd_reg;
        prod_next  = prod_reg;
        acc_next   = acc_reg;
        det_next   = det_reg;
        out_valid_next = out_xfer ? 1'b0 : out_valid_reg;
        for (int i = 0; i < MAX_SIZE; i++)
            digit_next[i] = digit_reg[i];

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_xfer)
                begin
                    if (count_reg + CW'(1) >= total)
                    begin
                        count_next = '0;
                        acc_next   = '0;
                        for (int i = 0; i < MAX_SIZE; i++)
                            digit_next[i] = '0;
                        state_next = ST_CHECK;
                    end
                    else
                        count_next = count_reg + CW'(1);
                end
            end
            ST_CHECK:
            begin
                if (distinct)
                begin
                    row_next   = '0;
                    odd_next   = parity;
                    prod_next  = DET_WIDTH'(1);
                    state_next = ST_READ;
                end
                else
                begin
                    for (int i = 0; i < MAX_SIZE; i++)
                        digit_next[i] = digit_inc[i];
                    state_next = wrap ? ST_OUT : ST_CHECK;
                end
            end
            ST_READ:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                prod_next = mul_full[DET_WIDTH-1:0];
                if (32'(row_reg) == 32'(size_eff) - 1)
                    state_next = ST_ACC;
                else
                begin
                    row_next   = row_reg + IW'(1);
                    state_next = ST_READ;
                end
            end
            ST_ACC:
            begin
                acc_next = odd_reg ? acc_reg - prod_reg : acc_reg + prod_reg;
                for (int i = 0; i < MAX_SIZE; i++)
                    digit_next[i] = digit_inc[i];
                state_next = wrap ? ST_OUT : ST_CHECK;
            end
            ST_OUT:
            begin
                // hand over once the output register is empty or draining
                if (!out_valid_reg || out_xfer)
                begin
                    det_next       = acc_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

// ----- sim/tb_integer_determinant_up_to_5x5.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_integer_determinant_up_to_5x5
// Checks the determinant block against a cofactor-expansion predictor for
// matrix sizes 0 to 7, with random gaps, a long output hold-off and
// size writes while the block is idle.
// ----------------------------------------------------------------------------
module tb_integer_determinant_up_to_5x5;

    import idud_pkg::*;

    localparam int N_DIM   = 5;
    localparam int WD_LIMIT = 200000;

    class det_scoreboard;
        logic signed [7:0] cells [N_DIM*N_DIM];
        int unsigned       loaded;
        int unsigned       size_reg;
        logic signed [DET_WIDTH-1:0] pending_dets [$];
        int                errors;

        function new();
            loaded   = 0;
            size_reg = 5;
            errors   = 0;
        endfunction

        function int unsigned eff_size();
            int unsigned s;
            s = size_reg & 7;
            if (s == 0) s = 1;
            if (s > N_DIM) s = N_DIM;
            return s;
        endfunction

        function void set_size(int unsigned v);
            size_reg = v;
            loaded   = 0;
        endfunction

        function longint cofactor_sum(int unsigned row, int unsigned used, int unsigned s);
            longint sum;
            int     pos;
            sum = 0;
            pos = 0;
            if (row >= s) return 1;
            for (int j = 0; j < s; j++)
            begin
                if (!used[j])
                begin
                    if (pos[0])
                        sum -= longint'(cells[row*s+j]) * cofactor_sum(row+1, used | (1 << j), s);
                    else
                        sum += longint'(cells[row*s+j]) * cofactor_sum(row+1, used | (1 << j), s);
                    pos++;
                end
            end
            return sum;
        endfunction

        function void note_element(logic signed [7:0] v);
            int unsigned s;
            longint      d;
            s = eff_size();
            if (loaded >= s*s) loaded = 0;
            cells[loaded] = v;
            loaded++;
            if (loaded == s*s)
            begin
                loaded = 0;
                d = cofactor_sum(0, 0, s);
                pending_dets.push_back(d[DET_WIDTH-1:0]);
            end
        endfunction

        // empty string on a match
        function string check_result(logic signed [DET_WIDTH-1:0] got);
            string msg;
            msg = "";
            if (pending_dets.size() == 0)
                msg = $sformatf("unexpected determinant %0d", got);
            else
            begin
                if (got !== pending_dets[0])
                    msg = $sformatf("determinant %0d, want %0d", got, pending_dets[0]);
                void'(pending_dets.pop_front());
            end
            return msg;
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic matrix_size_we;
    logic [CFG_WIDTH-1:0] matrix_size;
    logic in_valid;
    logic in_stall;
    logic signed [7:0] element_value;
    logic out_valid;
    logic out_stall;
    logic signed [DET_WIDTH-1:0] determinant;

    det_scoreboard sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_off;
    int  quiet_cycles;

    integer_determinant_up_to_5x5 i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .matrix_size_we (matrix_size_we),
        .matrix_size    (matrix_size),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .element_value  (element_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .determinant    (determinant)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        sb.errors++;
    endtask

    // valid stays high into the next item; dropped only while idling
    task automatic send_element(input logic signed [7:0] v);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        element_value <= v;
        do @(posedge clk); while (in_stall);
        sb.note_element(v);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (sb.pending_dets.size() != 0) @(negedge clk);
        repeat (5000) @(negedge clk);
    endtask

    task automatic write_size(input int unsigned v);
        in_valid <= 1'b0;
        wait_drained();
        matrix_size_we <= 1'b1;
        matrix_size    <= v[CFG_WIDTH-1:0];
        @(negedge clk);
        matrix_size_we <= 1'b0;
        sb.set_size(v);
    endtask

    function automatic logic signed [7:0] rand_elem();
        case ($urandom_range(5))
            0: return 8'sh80;
            1: return 8'sh7f;
            2: return 8'(int'($urandom_range(3)) - 1);
            default: return 8'($urandom);
        endcase
    endfunction

    // receiver: random stall, plus a forced hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= hold_off || (recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        string msg;
        if (rst_n && out_valid && !out_stall)
        begin
            msg = sb.check_result(determinant);
            if (msg != "")
                report_mismatch(msg);
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || matrix_size_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT)
        begin
            $display("[integer_determinant_up_to_5x5] ERROR");
            $finish;
        end
    end

    initial
    begin
        int unsigned sz;
        sb = new();
        rst_n = 1'b0;
        matrix_size_we = 1'b0;
        matrix_size = 3'd5;
        in_valid = 1'b0;
        element_value = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: size one extremes, sizes zero and above five, partial discard
        write_size(1);
        send_element(8'sh80); send_element(8'sd127); send_element(8'sd0); send_element(-8'sd1);
        write_size(0);
        send_element(8'sd1);
        write_size(2);
        send_element(8'sh80); send_element(8'sh80); send_element(8'sd127); send_element(8'sh80);
        send_element(8'sd5); send_element(8'sd3);
        write_size(3);
        for (int i = 0; i < 9; i++) send_element((i % 2) ? 8'sh80 : 8'sd127);
        write_size(7);
        for (int i = 0; i < 25; i++)
            send_element((i % 6 == 0) ? 8'sd127 : ((i % 6 == 1) ? 8'sh80 : 8'sd0));

        // random phases; size 5 matrices are slow so mostly small sizes
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 23 : ((ph == 1) ? 75 : 0);
            recv_idle_pct = (ph == 0) ? 75 : ((ph == 1) ? 23 : 0);
            for (int m = 0; m < 9; m++)
            begin
                sz = (m == 8) ? 5 : $urandom_range(6);
                write_size(sz);
                for (int k = 0; k < 18; k++)
                    send_element(rand_elem());
            end
        end

        // long output hold-off while elements keep coming
        write_size(2);
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(negedge clk);
                hold_off = 1'b0;
            end
            begin
                for (int k = 0; k < 24; k++) send_element(rand_elem());
                in_valid <= 1'b0;
            end
        join

        wait_drained();
        if (sb.errors == 0)
            $display("[integer_determinant_up_to_5x5] OK");
        else
            $display("[integer_determinant_up_to_5x5] ERROR");
        $finish;
    end

endmodule
